/* hw/rtl/crc32bsh_pkg.sv */
`default_nettype none

package crc32bsh_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W = 32;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } in_word_t;

    function automatic logic [CRC_W-1:0] fold_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/crc32bsh_in_stage.sv */
`default_nettype none

module crc32bsh_in_stage
    import crc32bsh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              data_valid,
    output logic                   data_ready,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              last_byte,
    input  wire logic              advance,
    output in_word_t               word
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              take;

    assign data_ready = !valid_reg || advance;
    assign take       = data_valid && data_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // hold the word until the hash stage takes it
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign word.valid = valid_reg;
    assign word.data  = byte_reg;
    assign word.last  = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/crc32bsh_hash_stage.sv */
`default_nettype none

module crc32bsh_hash_stage
    import crc32bsh_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire in_word_t         word,
    output logic                  advance,
    output logic                  hash_valid,
    input  wire logic             hash_ready,
    output logic [CRC_W-1:0]      hash_value
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] folded;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CRC_W-1:0] out_reg;
    logic             slot_free;
    logic             emit;

    assign folded    = fold_byte(crc_reg, word.data);
    assign slot_free = !out_valid_reg || hash_ready;
    assign advance   = word.valid && (!word.last || slot_free);
    assign emit      = advance && word.last;

    always_comb
    begin
        crc_next = crc_reg;
        if (advance)
            crc_next = word.last ? '0 : folded;
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (hash_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_reg <= folded;
    end

    assign hash_valid = out_valid_reg;
    assign hash_value = out_reg;

endmodule

`default_nettype wire

/* hw/rtl/crc32_byte_stream_hash.sv */
// Last byte: input register, then output register, which drives hash_valid.
// One byte per cycle unless a last byte waits; each CRC fold is combinational.
// A finished hash waits in the output register while further bytes are accepted;
// a last byte waits in the input register until the output register is free.
// Reset (rst_n low, asynchronous): CRC register cleared to zero, no word in flight.
`default_nettype none

module crc32_byte_stream_hash
    import crc32bsh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              data_valid,
    output logic                   data_ready,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              last_byte,
    output logic                   hash_valid,
    input  wire logic              hash_ready,
    output logic [CRC_W-1:0]       hash_value
);

    in_word_t word;
    logic     advance;

    crc32bsh_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .advance    (advance),
        .word       (word)
    );

    crc32bsh_hash_stage u_hash_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (word),
        .advance    (advance),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_value (hash_value)
    );

endmodule

`default_nettype wire

/* test/crc32_hash_checker.sv */
`default_nettype none

module crc32_hash_checker
    import crc32bsh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              data_valid,
    input  wire logic              data_ready,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              last_byte,
    input  wire logic              hash_valid,
    input  wire logic              hash_ready,
    input  wire logic [CRC_W-1:0]  hash_value,
    output int                     failures,
    output int                     pending_hashes
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [CRC_W-1:0] running_crc;
    logic [CRC_W-1:0] hash_queue[$];
    int               mismatch_count;

    initial
    begin
        failures       = 0;
        pending_hashes = 0;
        mismatch_count = 0;
        running_crc    = '0;
    end

    // shift one data bit at a time through the reflected feedback
    function automatic logic [CRC_W-1:0] crc_fold_octet(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] octet
    );
        logic [CRC_W-1:0] r;
        logic             feedback;
        r = crc;
        for (int i = 0; i < BYTE_W; i++)
        begin
            feedback = r[0] ^ octet[i];
            r = (r >> 1) ^ ({CRC_W{feedback}} & CRC_POLY);
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        logic [CRC_W-1:0] next_crc;
        logic [CRC_W-1:0] expected_hash;
        if (!rst_n)
        begin
            running_crc = '0;
            hash_queue.delete();
        end
        else
        begin
            if (hash_valid && hash_ready)
            begin
                if (hash_queue.size() == 0)
                begin
                    $error("hash_value: no hash expected, actual %08h", hash_value);
                    mismatch_count++;
                end
                else
                begin
                    expected_hash = hash_queue.pop_front();
                    if (hash_value !== expected_hash)
                    begin
                        $error("hash_value: expected %08h, actual %08h",
                               expected_hash, hash_value);
                        mismatch_count++;
                    end
                end
            end
            if (data_valid && data_ready)
            begin
                next_crc = crc_fold_octet(running_crc, data_byte);
                if (last_byte)
                begin
                    hash_queue.push_back(next_crc);
                    running_crc = '0;
                end
                else
                begin
                    running_crc = next_crc;
                end
            end
        end
        failures       <= mismatch_count;
        pending_hashes <= hash_queue.size();
    end

endmodule

`default_nettype wire

/* test/tb_crc32_byte_stream_hash.sv */
`default_nettype none

module tb_crc32_byte_stream_hash
    import crc32bsh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              data_valid = 1'b0;
    logic [BYTE_W-1:0] data_byte  = '0;
    logic              last_byte  = 1'b0;
    logic              hash_ready = 1'b0;
    logic              data_ready;
    logic              hash_valid;
    logic [CRC_W-1:0]  hash_value;
    int                failures;
    int                pending_hashes;

    int                byte_idle_pct  = 0;
    int                hash_stall_pct = 0;
    int                bytes_sent     = 0;

    crc32_byte_stream_hash DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_value (hash_value)
    );

    crc32_hash_checker hash_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_valid     (data_valid),
        .data_ready     (data_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .hash_valid     (hash_valid),
        .hash_ready     (hash_ready),
        .hash_value     (hash_value),
        .failures       (failures),
        .pending_hashes (pending_hashes)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        hash_ready <= ($urandom_range(0, 99) >= hash_stall_pct);
    end

    task automatic send_word(input logic [BYTE_W-1:0] value, input logic is_last);
        while ($urandom_range(0, 99) < byte_idle_pct)
        begin
            data_valid <= 1'b0;
            data_byte  <= BYTE_W'($urandom);
            last_byte  <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= value;
        last_byte  <= is_last;
        @(posedge clk);
        while (!data_ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_vector(input logic [BYTE_W-1:0] vec[$]);
        foreach (vec[i])
        begin
            send_word(vec[i], i == vec.size() - 1);
        end
    endtask

    // hold off the sender until every hash has been returned
    task automatic drain_hashes();
        data_valid <= 1'b0;
        @(posedge clk);
        while (pending_hashes != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic hash_random_vectors(input int byte_budget);
        logic [BYTE_W-1:0] vec[$];
        int                len;
        int                target;
        int                pick;
        target = bytes_sent + byte_budget;
        while (bytes_sent < target)
        begin
            vec.delete();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                              : $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    vec.push_back(8'h00);
                else if (pick == 1)
                    vec.push_back(8'hFF);
                else
                    vec.push_back(BYTE_W'($urandom));
            end
            send_vector(vec);
        end
    endtask

    initial
    begin
        logic [BYTE_W-1:0] vec[$];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        vec = '{8'h00};
        send_vector(vec);
        vec = '{8'hFF};
        send_vector(vec);
        vec = '{8'h01};
        send_vector(vec);
        vec = '{8'h80};
        send_vector(vec);
        vec = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_vector(vec);
        vec = '{8'h00, 8'hAA};
        send_vector(vec);
        vec = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        send_vector(vec);
        drain_hashes();

        hash_random_vectors(420);
        drain_hashes();

        byte_idle_pct  = 78;
        hash_stall_pct <= 0;
        hash_random_vectors(420);
        drain_hashes();

        byte_idle_pct  = 0;
        hash_stall_pct <= 78;
        hash_random_vectors(420);
        drain_hashes();

        byte_idle_pct  = 20;
        hash_stall_pct <= 20;
        hash_random_vectors(420);
        drain_hashes();

        repeat (20) @(posedge clk);
        if (failures == 0 && pending_hashes == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
